[rtl/core/rtpap_pkg.sv]
// Package for the RTP audio packetizer: shared constants, register indexes,
// and the command/status structs between controller and datapath.
// No dependencies.
package rtpap_pkg;

    localparam int PACKET_MARGIN = 4;
    localparam int MAX_CHANNELS  = 64;
    localparam int HEADER_BYTES  = 12;

    // config register indexes
    localparam logic [2:0] REG_MTU          = 3'd0;
    localparam logic [2:0] REG_CHANNELS     = 3'd1;
    localparam logic [2:0] REG_BPS          = 3'd2;
    localparam logic [2:0] REG_BLOCK_FRAMES = 3'd3;
    localparam logic [2:0] REG_PAYLOAD_TYPE = 3'd4;
    localparam logic [2:0] REG_SOURCE_ID    = 3'd5;

    localparam logic [15:0] MTU_RESET          = 16'd1500;
    localparam logic [6:0]  CHANNELS_RESET     = 7'd2;
    localparam logic [2:0]  BPS_RESET          = 3'd2;
    localparam logic [12:0] BLOCK_FRAMES_RESET = 13'd1024;
    localparam logic [6:0]  PAYLOAD_TYPE_RESET = 7'd96;

    localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;

    // divider widths: payload size and frame size in bytes
    localparam int PSIZE_W = 16;
    localparam int FB_W    = 9;

    typedef struct packed {
        logic load_byte;
        logic calc_fb;
        logic start_block;
        logic drop_byte;
        logic start_div;
        logic set_packet;
        logic emit_err;
        logic emit_hdr;
        logic emit_pay;
    } cmd_t;

    typedef struct packed {
        logic block_empty;
        logic size_zero;
        logic dropping;
        logic pkt_empty;
        logic div_busy;
        logic psize_zero;
        logic hdr_last;
        logic out_room;
    } status_t;

endpackage

[rtl/core/rtp_audio_packetizer.sv]
// Channel      Direction  Handshake              Payload
// s_axis       in         s_axis_tvalid/tready   tdata[7:0] payload_byte
// m_axis       out        m_axis_tvalid/tready   tdata out_byte, tlast packet_end, tuser flags
// cfg          in         cfg_valid/cfg_ready    cfg_index[2:0], cfg_data[31:0]
//
// A byte inside a packet is accepted, checked and emitted. The first byte of
// a block also runs the block size multiply; the first byte of a packet also runs
// the 16-step restoring divider, the sizing and the 12 header bytes.
// A byte that finds no whole frame emits an error; a dropped byte is not emitted.
// Reset clears counters and RTP state and loads the config defaults.
// The output register frees the controller; further output stalls hold it in place.
// Top level of the RTP audio packetizer: controller plus datapath.
// Depends on rtpap_pkg, rtpap_ctrl, rtpap_dp.
module rtp_audio_packetizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] payload_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser,   // [0] is_header, [1] empty_error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    rtpap_pkg::cmd_t    cmd;
    rtpap_pkg::status_t status;

    assign cfg_ready = 1'b1;

    rtpap_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rtpap_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_byte    (s_axis_tdata),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_byte   (m_axis_tdata),
        .out_header (m_axis_tuser[0]),
        .out_end    (m_axis_tlast),
        .out_error  (m_axis_tuser[1])
    );

endmodule

[rtl/core/rtpap_div.sv]
// Restoring divider for the RTP packetizer: payload bytes / frame bytes,
// one quotient bit per cycle. Depends on rtpap_pkg.
module rtpap_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [rtpap_pkg::PSIZE_W-1:0]     dividend,
    input  logic [rtpap_pkg::FB_W-1:0]        divisor,
    output logic                              busy,
    output logic [rtpap_pkg::PSIZE_W-1:0]     quotient,
    output logic [rtpap_pkg::FB_W-1:0]        remainder
);

    logic [rtpap_pkg::PSIZE_W-1:0] quo_reg;
    logic [rtpap_pkg::FB_W-1:0]    rem_reg;
    logic [rtpap_pkg::FB_W-1:0]    div_reg;
    logic [4:0]                    cnt_reg;
    logic                          busy_reg;

    logic [rtpap_pkg::FB_W:0]      rem_w;
    logic                          ge;
    logic [rtpap_pkg::FB_W:0]      rem_sub;

    assign rem_w   = {rem_reg, quo_reg[rtpap_pkg::PSIZE_W-1]};
    assign ge      = rem_w >= {1'b0, div_reg};
    assign rem_sub = rem_w - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'(rtpap_pkg::PSIZE_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 5'd0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[rtpap_pkg::PSIZE_W-2:0], ge};
            rem_reg <= ge ? rem_sub[rtpap_pkg::FB_W-1:0] : rem_w[rtpap_pkg::FB_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/core/rtpap_dp.sv]
// Datapath of the RTP packetizer: config registers, RTP header state,
// block/packet counters, divider and output register. Depends on rtpap_pkg, rtpap_div.
module rtpap_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rtpap_pkg::cmd_t      cmd,
    output rtpap_pkg::status_t   status,
    input  logic [7:0]           in_byte,
    input  logic                 cfg_write,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [7:0]           out_byte,
    output logic                 out_header,
    output logic                 out_end,
    output logic                 out_error
);

    // configuration
    logic [15:0] mtu_reg;
    logic [6:0]  channels_reg;
    logic [2:0]  bps_reg;
    logic [12:0] block_frames_reg;
    logic [6:0]  payload_type_reg;
    logic [31:0] source_id_reg;

    // RTP and framing state
    logic [15:0] seq_reg;
    logic [31:0] ts_reg;
    logic        marker_reg;
    logic [23:0] block_left_reg;
    logic [15:0] pkt_left_reg;
    logic [15:0] pkt_frames_reg;
    logic        dropping_reg;
    logic [3:0]  hdr_cnt_reg;

    // per-item working registers
    logic [7:0]                    byte_reg;
    logic [rtpap_pkg::FB_W-1:0]    fb_reg;
    logic [rtpap_pkg::PSIZE_W-1:0] psize_reg;

    // output register
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_header_reg;
    logic        out_end_reg;
    logic        out_error_reg;

    logic [9:0]                    fb_prod;
    logic [21:0]                   size_prod;
    logic [15:0]                   cap;
    logic [15:0]                   psize_pre;
    logic [15:0]                   psize_final;
    logic                          div_busy;
    logic [rtpap_pkg::PSIZE_W-1:0] div_quo;
    logic [rtpap_pkg::FB_W-1:0]    div_rem;
    logic [7:0]                    hdr_byte;
    logic [15:0]                   pkt_left_dec;
    logic                          chan_ok;

    assign fb_prod   = {3'd0, channels_reg} * {7'd0, bps_reg};
    assign size_prod = {13'd0, fb_reg} * {9'd0, block_frames_reg};

    assign cap = (mtu_reg > 16'(rtpap_pkg::HEADER_BYTES))
               ? mtu_reg - 16'(rtpap_pkg::HEADER_BYTES) : 16'd0;

    always_comb
    begin
        if ({8'd0, cap} > block_left_reg)
            psize_pre = block_left_reg[15:0];
        else if (cap > 16'(2 * rtpap_pkg::PACKET_MARGIN))
            psize_pre = cap - 16'(rtpap_pkg::PACKET_MARGIN);
        else
            psize_pre = cap;
    end

    // whole frames only: drop the remainder
    assign psize_final = psize_reg - {7'd0, div_rem};

    // divisor comes straight from the registers: fb_reg loads on the same edge
    rtpap_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.start_div),
        .dividend  (psize_pre),
        .divisor   (fb_prod[rtpap_pkg::FB_W-1:0]),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        case (hdr_cnt_reg)
            4'd0:    hdr_byte = rtpap_pkg::RTP_VERSION_BYTE;
            4'd1:    hdr_byte = {marker_reg, payload_type_reg};
            4'd2:    hdr_byte = seq_reg[15:8];
            4'd3:    hdr_byte = seq_reg[7:0];
            4'd4:    hdr_byte = ts_reg[31:24];
            4'd5:    hdr_byte = ts_reg[23:16];
            4'd6:    hdr_byte = ts_reg[15:8];
            4'd7:    hdr_byte = ts_reg[7:0];
            4'd8:    hdr_byte = source_id_reg[31:24];
            4'd9:    hdr_byte = source_id_reg[23:16];
            4'd10:   hdr_byte = source_id_reg[15:8];
            4'd11:   hdr_byte = source_id_reg[7:0];
            default: hdr_byte = 8'd0;
        endcase
    end

    assign pkt_left_dec = pkt_left_reg - 16'd1;
    assign chan_ok = (cfg_data[6:0] != 7'd0) && (cfg_data[6:0] <= 7'(rtpap_pkg::MAX_CHANNELS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mtu_reg          <= rtpap_pkg::MTU_RESET;
            channels_reg     <= rtpap_pkg::CHANNELS_RESET;
            bps_reg          <= rtpap_pkg::BPS_RESET;
            block_frames_reg <= rtpap_pkg::BLOCK_FRAMES_RESET;
            payload_type_reg <= rtpap_pkg::PAYLOAD_TYPE_RESET;
            source_id_reg    <= 32'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rtpap_pkg::REG_MTU:          mtu_reg <= cfg_data[15:0];
                rtpap_pkg::REG_CHANNELS:
                begin
                    if (chan_ok)
                        channels_reg <= cfg_data[6:0];
                end
                rtpap_pkg::REG_BPS:          bps_reg <= cfg_data[2:0];
                rtpap_pkg::REG_BLOCK_FRAMES: block_frames_reg <= cfg_data[12:0];
                rtpap_pkg::REG_PAYLOAD_TYPE: payload_type_reg <= cfg_data[6:0];
                rtpap_pkg::REG_SOURCE_ID:    source_id_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg        <= 16'd0;
            ts_reg         <= 32'd0;
            marker_reg     <= 1'b1;
            block_left_reg <= 24'd0;
            pkt_left_reg   <= 16'd0;
            pkt_frames_reg <= 16'd0;
            dropping_reg   <= 1'b0;
            hdr_cnt_reg    <= 4'd0;
        end
        else
        begin
            if (cmd.start_block)
            begin
                block_left_reg <= {2'd0, size_prod};
                pkt_left_reg   <= 16'd0;
                dropping_reg   <= 1'b0;
            end
            if (cmd.drop_byte)
                block_left_reg <= block_left_reg - 24'd1;
            if (cmd.emit_err)
            begin
                dropping_reg   <= 1'b1;
                block_left_reg <= block_left_reg - 24'd1;
            end
            if (cmd.set_packet)
            begin
                pkt_left_reg   <= psize_final;
                pkt_frames_reg <= div_quo;
                hdr_cnt_reg    <= 4'd0;
            end
            if (cmd.emit_hdr)
                hdr_cnt_reg <= hdr_cnt_reg + 4'd1;
            if (cmd.emit_pay)
            begin
                pkt_left_reg   <= pkt_left_dec;
                block_left_reg <= block_left_reg - 24'd1;
                if (pkt_left_dec == 16'd0)
                begin
                    seq_reg    <= seq_reg + 16'd1;
                    ts_reg     <= ts_reg + {16'd0, pkt_frames_reg};
                    marker_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
            byte_reg <= in_byte;
        if (cmd.calc_fb)
            fb_reg <= fb_prod[rtpap_pkg::FB_W-1:0];
        if (cmd.start_div)
            psize_reg <= psize_pre;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_err || cmd.emit_hdr || cmd.emit_pay)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_err)
        begin
            out_byte_reg   <= 8'd0;
            out_header_reg <= 1'b0;
            out_end_reg    <= 1'b0;
            out_error_reg  <= 1'b1;
        end
        else if (cmd.emit_hdr)
        begin
            out_byte_reg   <= hdr_byte;
            out_header_reg <= 1'b1;
            out_end_reg    <= 1'b0;
            out_error_reg  <= 1'b0;
        end
        else if (cmd.emit_pay)
        begin
            out_byte_reg   <= byte_reg;
            out_header_reg <= 1'b0;
            out_end_reg    <= (pkt_left_reg == 16'd1);
            out_error_reg  <= 1'b0;
        end
    end

    always_comb
    begin
        status.block_empty = (block_left_reg == 24'd0);
        status.size_zero   = (size_prod == 22'd0);
        status.dropping    = dropping_reg;
        status.pkt_empty   = (pkt_left_reg == 16'd0);
        status.div_busy    = div_busy;
        // a zero frame size means no whole frame fits
        status.psize_zero  = (fb_reg == '0) || (psize_final == 16'd0);
        status.hdr_last    = (hdr_cnt_reg == 4'(rtpap_pkg::HEADER_BYTES - 1));
        status.out_room    = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_header = out_header_reg;
    assign out_end    = out_end_reg;
    assign out_error  = out_error_reg;

endmodule

[rtl/core/rtpap_ctrl.sv]
// Controller state machine of the RTP packetizer: sequences block start,
// packet sizing, header and payload output. Depends on rtpap_pkg.
module rtpap_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rtpap_pkg::status_t   status,
    output rtpap_pkg::cmd_t      cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FB    = 4'd1;
    localparam logic [3:0] S_SIZE  = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_PSIZE = 4'd5;
    localparam logic [3:0] S_ERR   = 4'd6;
    localparam logic [3:0] S_HDR   = 4'd7;
    localparam logic [3:0] S_PAY   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_byte = 1'b1;
                    state_next    = status.block_empty ? S_FB : S_CHECK;
                end
            end
            S_FB:
            begin
                cmd.calc_fb = 1'b1;
                state_next  = S_SIZE;
            end
            S_SIZE:
            begin
                if (status.size_zero)
                    state_next = S_IDLE;
                else
                begin
                    cmd.start_block = 1'b1;
                    state_next      = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.dropping)
                begin
                    cmd.drop_byte = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (status.pkt_empty)
                begin
                    // frame size may have changed since the block started
                    cmd.calc_fb   = 1'b1;
                    cmd.start_div = 1'b1;
                    state_next    = S_DIV;
                end
                else
                    state_next = S_PAY;
            end
            S_DIV:
            begin
                if (!status.div_busy)
                    state_next = S_PSIZE;
            end
            S_PSIZE:
            begin
                if (status.psize_zero)
                    state_next = S_ERR;
                else
                begin
                    cmd.set_packet = 1'b1;
                    state_next     = S_HDR;
                end
            end
            S_ERR:
            begin
                if (status.out_room)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_HDR:
            begin
                if (status.out_room)
                begin
                    cmd.emit_hdr = 1'b1;
                    if (status.hdr_last)
                        state_next = S_PAY;
                end
            end
            S_PAY:
            begin
                if (status.out_room)
                begin
                    cmd.emit_pay = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/rtpap_checker.sv]
// Port-level checker for the RTP packetizer, bound to the top level.
// Depends on rtp_audio_packetizer ports only.
module rtpap_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic [1:0]  m_axis_tuser
);

    // header bytes never close a packet
    a_hdr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tlast)
        else $error("header byte marked as packet end");

    // error transaction carries nothing else
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            !m_axis_tuser[0] && !m_axis_tlast && (m_axis_tdata == 8'd0))
        else $error("error transaction with data or flags");

    // a header byte is followed by more packet bytes, not an error
    a_hdr_then_pkt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser[0] ##1 m_axis_tvalid
            |-> !m_axis_tuser[1])
        else $error("error transaction inside a header");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled output changed");

endmodule

bind rtp_audio_packetizer rtpap_checker u_rtpap_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

[dv/rtp_audio_packetizer_check.sv]
// Checker for the RTP audio packetizer: watches the cfg, s_axis and m_axis channels,
// predicts every packet byte from its own copy of the registers and RTP state.
// Depends on rtpap_pkg.
module rtp_audio_packetizer_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic [1:0]  m_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          consumed,
    output logic [23:0] block_left
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       hdr;
        logic       last;
        logic       err;
    } pkt_byte_t;

    pkt_byte_t due_bytes[$];

    // shadow registers
    logic [15:0] mtu_q;
    logic [6:0]  chans_q;
    logic [2:0]  bps_q;
    logic [12:0] frames_q;
    logic [6:0]  ptype_q;
    logic [31:0] ssrc_q;

    // RTP and framing state
    logic [15:0] seq_q;
    logic [31:0] ts_q;
    logic        marker_q;
    logic [15:0] pkt_left;
    logic [15:0] pkt_frames;
    logic        dropping;

    task automatic expect_byte(input logic [7:0] d, input logic h, input logic l,
                               input logic e);
        pkt_byte_t b;
        b.data = d;
        b.hdr  = h;
        b.last = l;
        b.err  = e;
        due_bytes.push_back(b);
    endtask

    task automatic packetize(input logic [7:0] b);
        int unsigned size;
        int unsigned fbytes;
        int unsigned cap;
        int unsigned psize;
        int unsigned nframes;
        int unsigned hdr_len;
        int unsigned margin;
        logic        ignore;
        ignore  = 1'b0;
        hdr_len = 32'(rtpap_pkg::HEADER_BYTES);
        margin  = 32'(rtpap_pkg::PACKET_MARGIN);
        if (block_left == 24'd0)
        begin
            size = 32'(chans_q) * 32'(frames_q) * 32'(bps_q);
            if (size == 32'd0)
                ignore = 1'b1;
            else
            begin
                block_left = size[23:0];
                pkt_left   = 16'd0;
                dropping   = 1'b0;
            end
        end
        if (!ignore)
        begin
            consumed++;
            if (dropping)
                block_left--;
            else
            begin
                if (pkt_left == 16'd0)
                begin
                    fbytes = 32'(chans_q) * 32'(bps_q);
                    cap = (32'(mtu_q) > hdr_len) ? 32'(mtu_q) - hdr_len : 32'd0;
                    if (cap > {8'd0, block_left})
                        psize = {8'd0, block_left};
                    else
                    begin
                        psize = cap;
                        if (psize > 32'd2 * margin)
                            psize = psize - margin;
                    end
                    nframes = (fbytes != 32'd0) ? psize / fbytes : 32'd0;
                    psize = nframes * fbytes;
                    if (psize == 32'd0)
                    begin
                        // no whole frame fits: flag it, drop the rest of the block
                        expect_byte(8'h00, 1'b0, 1'b0, 1'b1);
                        dropping = 1'b1;
                        block_left--;
                    end
                    else
                    begin
                        expect_byte(rtpap_pkg::RTP_VERSION_BYTE, 1'b1, 1'b0, 1'b0);
                        expect_byte({marker_q, ptype_q}, 1'b1, 1'b0, 1'b0);
                        expect_byte(seq_q[15:8], 1'b1, 1'b0, 1'b0);
                        expect_byte(seq_q[7:0], 1'b1, 1'b0, 1'b0);
                        expect_byte(ts_q[31:24], 1'b1, 1'b0, 1'b0);
                        expect_byte(ts_q[23:16], 1'b1, 1'b0, 1'b0);
                        expect_byte(ts_q[15:8], 1'b1, 1'b0, 1'b0);
                        expect_byte(ts_q[7:0], 1'b1, 1'b0, 1'b0);
                        expect_byte(ssrc_q[31:24], 1'b1, 1'b0, 1'b0);
                        expect_byte(ssrc_q[23:16], 1'b1, 1'b0, 1'b0);
                        expect_byte(ssrc_q[15:8], 1'b1, 1'b0, 1'b0);
                        expect_byte(ssrc_q[7:0], 1'b1, 1'b0, 1'b0);
                        pkt_left   = psize[15:0];
                        pkt_frames = nframes[15:0];
                    end
                end
                if (!dropping)
                begin
                    expect_byte(b, 1'b0, pkt_left == 16'd1, 1'b0);
                    pkt_left--;
                    block_left--;
                    if (pkt_left == 16'd0)
                    begin
                        seq_q    = seq_q + 16'd1;
                        ts_q     = ts_q + {16'd0, pkt_frames};
                        marker_q = 1'b0;
                    end
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pkt_byte_t exp;
        if (!rst_n)
        begin
            due_bytes.delete();
            mtu_q      = rtpap_pkg::MTU_RESET;
            chans_q    = rtpap_pkg::CHANNELS_RESET;
            bps_q      = rtpap_pkg::BPS_RESET;
            frames_q   = rtpap_pkg::BLOCK_FRAMES_RESET;
            ptype_q    = rtpap_pkg::PAYLOAD_TYPE_RESET;
            ssrc_q     = 32'd0;
            seq_q      = 16'd0;
            ts_q       = 32'd0;
            marker_q   = 1'b1;
            block_left = 24'd0;
            pkt_left   = 16'd0;
            pkt_frames = 16'd0;
            dropping   = 1'b0;
            errors     = 0;
            consumed   = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rtpap_pkg::REG_MTU:          mtu_q = cfg_data[15:0];
                    rtpap_pkg::REG_CHANNELS:
                        if (cfg_data[6:0] >= 7'd1
                            && cfg_data[6:0] <= 7'(rtpap_pkg::MAX_CHANNELS))
                            chans_q = cfg_data[6:0];
                    rtpap_pkg::REG_BPS:          bps_q = cfg_data[2:0];
                    rtpap_pkg::REG_BLOCK_FRAMES: frames_q = cfg_data[12:0];
                    rtpap_pkg::REG_PAYLOAD_TYPE: ptype_q = cfg_data[6:0];
                    rtpap_pkg::REG_SOURCE_ID:    ssrc_q = cfg_data;
                    default: ;
                endcase
            end

            // output first: it can only stem from earlier input transactions
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_bytes.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected packet byte: expected none, actual %h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    exp = due_bytes.pop_front();
                    if (m_axis_tdata !== exp.data)
                    begin
                        errors++;
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, exp.data, m_axis_tdata);
                    end
                    if (m_axis_tuser[0] !== exp.hdr)
                    begin
                        errors++;
                        $display("%0t: is_header expected %b actual %b",
                                 $time, exp.hdr, m_axis_tuser[0]);
                    end
                    if (m_axis_tlast !== exp.last)
                    begin
                        errors++;
                        $display("%0t: packet_end expected %b actual %b",
                                 $time, exp.last, m_axis_tlast);
                    end
                    if (m_axis_tuser[1] !== exp.err)
                    begin
                        errors++;
                        $display("%0t: empty_error expected %b actual %b",
                                 $time, exp.err, m_axis_tuser[1]);
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                packetize(s_axis_tdata);

            pending = due_bytes.size();
        end
    end

endmodule

[dv/rtp_audio_packetizer_test.sv]
// Testbench top for the RTP audio packetizer: clock, reset, register writes and
// payload byte stimulus with random stalls; verdict from the checker's error count and pending bytes.
// Depends on rtpap_pkg, rtp_audio_packetizer, rtp_audio_packetizer_check.
module rtp_audio_packetizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS  = 450;
    localparam int SETTLE = 32;
    localparam int LIMIT  = 400000;

    // indexes outside the register map, written to show they do nothing
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [31:0] cfg_data = 32'd0;

    int          errors;
    int          pending;
    int          consumed;
    logic [23:0] block_left;
    int          cycles = 0;
    bit          calm = 1'b0;

    rtp_audio_packetizer uut (.*);

    rtp_audio_packetizer_check packet_check (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("rtp_audio_packetizer_test: FAIL");
            $finish;
        end
    end

    always @(negedge clk)
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 12);

    function automatic logic [31:0] with_junk(input logic [31:0] v, input int w);
        logic [31:0] r;
        r = v;
        if ($urandom_range(0, 3) == 0)
            r = (($urandom() >> w) << w) | v;
        return r;
    endfunction

    function automatic logic [15:0] pick_mtu();
        int r;
        logic [15:0] m;
        r = int'($urandom_range(0, 99));
        if (r < 60)
            m = 16'($urandom_range(13, 60));
        else if (r < 80)
            m = 16'($urandom_range(13, 24));
        else if (r < 92)
            m = 16'($urandom_range(0, 65535));
        else
            m = 16'($urandom_range(0, 12));
        return m;
    endfunction

    task automatic send_byte(input logic [7:0] d);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_bytes(input int n);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // block drained: nothing owed, and time for a dropped or ignored byte to retire
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_sizes(input logic [6:0] c, input logic [2:0] bp,
                             input logic [12:0] fr);
        write_reg(rtpap_pkg::REG_CHANNELS, with_junk(32'(c), 7));
        write_reg(rtpap_pkg::REG_BPS, with_junk(32'(bp), 3));
        write_reg(rtpap_pkg::REG_BLOCK_FRAMES, with_junk(32'(fr), 13));
    endtask

    // huge frame against a short remainder; sizes must be restored before the block ends
    task automatic send_at_extremes();
        write_reg(rtpap_pkg::REG_MTU, 32'd65535);
        write_reg(rtpap_pkg::REG_CHANNELS, 32'(rtpap_pkg::MAX_CHANNELS));
        write_reg(rtpap_pkg::REG_BPS, 32'd7);
        write_reg(rtpap_pkg::REG_BLOCK_FRAMES, 32'd8191);
        send_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int phase;
        int kind;
        logic [6:0]  c;
        logic [2:0]  bp;
        logic [12:0] fr;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values in the header: one short block of 4 bytes
        write_reg(rtpap_pkg::REG_BLOCK_FRAMES, 32'd1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);

        wait_idle();
        set_sizes(7'd1, 3'd1, 13'd6);
        write_reg(rtpap_pkg::REG_MTU, 32'd15);
        write_reg(rtpap_pkg::REG_PAYLOAD_TYPE, 32'd127);
        write_reg(rtpap_pkg::REG_SOURCE_ID, 32'hFFFF_FFFF);
        send_bytes(3);

        // mid-block: frame larger than what is left
        wait_idle();
        send_at_extremes();

        wait_idle();
        set_sizes(7'd1, 3'd1, 13'd2);
        write_reg(rtpap_pkg::REG_CHANNELS, 32'd0);
        write_reg(rtpap_pkg::REG_CHANNELS, 32'd127);
        write_reg(rtpap_pkg::REG_MTU, 32'd13);
        write_reg(rtpap_pkg::REG_PAYLOAD_TYPE, 32'd0);
        write_reg(rtpap_pkg::REG_SOURCE_ID, 32'd0);
        write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_B, 32'h1234_5678);
        send_bytes(4);

        // payload cap exactly twice the margin, then a 1-byte tail packet
        wait_idle();
        write_reg(rtpap_pkg::REG_MTU, 32'd20);
        write_reg(rtpap_pkg::REG_BLOCK_FRAMES, 32'd9);
        send_bytes(9);

        wait_idle();
        write_reg(rtpap_pkg::REG_BPS, 32'd0);
        send_bytes(2);

        wait_idle();
        write_reg(rtpap_pkg::REG_BPS, 32'd1);
        write_reg(rtpap_pkg::REG_BLOCK_FRAMES, 32'd3);
        write_reg(rtpap_pkg::REG_MTU, 32'd12);
        send_bytes(3);

        phase = 0;
        while (consumed < ITEMS)
        begin
            calm = (phase >= 12 && phase < 20);
            kind = int'($urandom_range(0, 99));
            wait_idle();
            c  = 7'($urandom_range(1, 3));
            bp = 3'($urandom_range(1, 3));
            fr = 13'($urandom_range(1, 4));
            if (kind < 70)
            begin
                set_sizes(c, bp, fr);
                write_reg(rtpap_pkg::REG_MTU, with_junk(32'(pick_mtu()), 16));
                if ($urandom_range(0, 1) == 1)
                    write_reg(rtpap_pkg::REG_PAYLOAD_TYPE,
                              with_junk($urandom_range(0, 127), 7));
                if ($urandom_range(0, 3) == 0)
                    write_reg(rtpap_pkg::REG_SOURCE_ID, $urandom());
                send_bytes(int'({8'd0, block_left})
                           + int'(c) * int'(bp) * int'(fr) * int'($urandom_range(1, 2)));
            end
            else if (kind < 82)
            begin
                // sizes change mid-block; frame size and MTU apply from the next packet
                set_sizes(c, bp, fr);
                write_reg(rtpap_pkg::REG_MTU, 32'(pick_mtu()));
                if (block_left >= 24'd2)
                    send_bytes(int'($urandom_range(1, {8'd0, block_left} - 32'd1)));
                else
                    send_bytes(int'($urandom_range(1, 6)));
            end
            else if (kind < 87)
            begin
                if (block_left >= 24'd2)
                begin
                    send_at_extremes();
                    wait_idle();
                    set_sizes(c, bp, fr);
                    write_reg(rtpap_pkg::REG_MTU, 32'(pick_mtu()));
                end
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0: write_reg(rtpap_pkg::REG_CHANNELS, $urandom() << 7);
                    1: write_reg(rtpap_pkg::REG_CHANNELS,
                                 ($urandom() << 7) | $urandom_range(65, 127));
                    2: write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
                    3:
                    begin
                        write_reg(rtpap_pkg::REG_BPS, with_junk(32'd0, 3));
                        send_bytes(int'($urandom_range(1, 4)));
                        wait_idle();
                        write_reg(rtpap_pkg::REG_BPS, 32'(bp));
                    end
                    4:
                    begin
                        write_reg(rtpap_pkg::REG_BLOCK_FRAMES, with_junk(32'd0, 13));
                        send_bytes(int'($urandom_range(1, 4)));
                        wait_idle();
                        write_reg(rtpap_pkg::REG_BLOCK_FRAMES, 32'(fr));
                    end
                    default:
                    begin
                        set_sizes(7'd1, 3'($urandom_range(5, 7)), 13'($urandom_range(1, 2)));
                        write_reg(rtpap_pkg::REG_MTU, $urandom_range(13, 40));
                        send_bytes(int'({8'd0, block_left}));
                    end
                endcase
                send_bytes(int'($urandom_range(1, 8)));
            end
            phase++;
        end
        calm = 1'b0;

        wait_idle();
        if (errors == 0 && pending == 0)
            $display("rtp_audio_packetizer_test: PASS");
        else
            $display("rtp_audio_packetizer_test: FAIL");
        $finish;
    end

endmodule
